[rtl/srpc_pkg.sv]
// Shared types, constants and arithmetic helpers for the scene radius and patch corner block.
// No dependencies; every other file imports this package.
package srpc_pkg;

    localparam int COORD_W   = 24;
    localparam int FRAC_BITS = 12;
    localparam int SQ_W      = 50;                      // squared distance width
    localparam int ROOT_W    = SQ_W / 2;                // 25-bit root
    localparam int REM_W     = ROOT_W + 1;
    localparam int AREA_ITER = (COORD_W + FRAC_BITS) / 2;
    localparam int TAN_W     = COORD_W + COORD_W / 2 - FRAC_BITS + 6; // unsaturated scaled tangent
    localparam int S_W       = AREA_ITER - 1;           // scale factor width
    localparam int PROD_W    = S_W + 1 + COORD_W;
    localparam int SUM_W     = TAN_W + 2;
    localparam int SQP_W     = 2 * COORD_W;
    localparam int GEN_W     = 32;
    localparam int ITER_W    = 5;

    localparam logic [1:0] KIND_CORNER = 2'd0;
    localparam logic [1:0] KIND_TAN1   = 2'd1;
    localparam logic [1:0] KIND_TAN2   = 2'd2;
    localparam logic [1:0] KIND_RADIUS = 2'd3;

    typedef struct packed {
        logic                      cmd;
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
        logic        [COORD_W-1:0] area;
        logic                      last_item;
    } t_item;

    typedef struct packed {
        logic        [1:0]         kind;
        logic        [1:0]         corner_index;
        logic signed [COORD_W-1:0] vec_x;
        logic signed [COORD_W-1:0] vec_y;
        logic signed [COORD_W-1:0] vec_z;
        logic        [COORD_W:0]   radius;
        logic        [GEN_W-1:0]   generation;
        logic                      last_result;
    } t_result;

    // Square root unit handshake.
    typedef struct packed {
        logic              start;
        logic [SQ_W-1:0]   rad;
        logic [ITER_W-1:0] iters;
    } t_sqrt_req;

    function automatic logic signed [COORD_W-1:0] sat_c(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
        lo = -hi - SUM_W'(1);
        if (v > hi)
            return COORD_W'(hi);
        else if (v < lo)
            return COORD_W'(lo);
        return v[COORD_W-1:0];
    endfunction

    // Round to nearest, ties toward +inf: add half then floor shift.
    function automatic logic signed [TAN_W-1:0] round_t(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] q;
        q = (p + PROD_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
        return q[TAN_W-1:0];
    endfunction

endpackage

[rtl/srpc_front.sv]
// Front side: two-entry request queue that accepts and holds incoming items.
// Depends on srpc_pkg.
module srpc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  srpc_pkg::t_item i_item,
    output logic           o_q_empty,
    input  logic           i_q_pop,
    output srpc_pkg::t_item o_q_item
);
    import srpc_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign full      = (r_cnt == 2'd2);
    assign o_q_empty = (r_cnt == 2'd0);
    assign o_q_item  = r_mem[r_rp];
    assign wr        = push && !full;
    assign rd        = i_q_pop && !o_q_empty;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end
endmodule

[rtl/srpc_isqrt.sv]
// Iterative integer square root, one result bit per cycle, radicand left aligned.
// Depends on srpc_pkg.
module srpc_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  srpc_pkg::t_sqrt_req         i_req,
    output logic                        o_done,
    output logic [srpc_pkg::ROOT_W-1:0] o_root
);
    import srpc_pkg::*;

    logic [SQ_W-1:0]   r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [ITER_W-1:0] r_left;
    logic              r_busy;
    logic [REM_W+1:0]  rem_t, trial;

    assign rem_t  = {r_rem, r_rad[SQ_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_rad  <= i_req.rad;
                r_rem  <= '0;
                r_root <= '0;
                r_left <= i_req.iters;
            end else if (r_busy) begin
                if (rem_t >= trial) begin
                    r_rem  <= REM_W'(rem_t - trial);
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= REM_W'(rem_t);
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
                r_rad  <= {r_rad[SQ_W-3:0], 2'b00};
                r_left <= r_left - ITER_W'(1);
                if (r_left == ITER_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

[rtl/srpc_back.sv]
// Back side: sequencer with a scaling multiplier and a squarer that scales tangents, forms corners,
// tracks the maximum squared distance and emits results. Depends on srpc_pkg, srpc_isqrt.
module srpc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    output logic              o_q_pop,
    input  srpc_pkg::t_item   i_q_item,
    input  logic              i_out_full,
    output logic              o_out_push,
    output srpc_pkg::t_result o_out
);
    import srpc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SQRT, S_MUL, S_EMIT_T1, S_EMIT_T2, S_CORNER, S_DIST, S_EMIT_C, S_EMIT_R
    } t_state;
    typedef enum logic [1:0] {P_WIRE_A, P_WIRE_B, P_CORNER} t_phase;

    t_state                    r_state;
    t_phase                    r_phase;
    t_item                     r_item;
    logic [S_W-1:0]            r_s;
    logic signed [TAN_W-1:0]   r_t [6];
    logic signed [PROD_W-1:0]  r_mprod;
    logic [2:0]                r_midx;
    logic [1:0]                r_k, r_didx;
    logic signed [COORD_W-1:0] r_v [3];
    logic signed [SQP_W-1:0]   r_prod;
    logic [SQ_W-1:0]           r_acc, r_max, sum;
    logic [GEN_W-1:0]          r_deck;
    logic                      r_sqrt_radius;
    t_sqrt_req                 sq_req;
    logic                      sq_done;
    logic [ROOT_W-1:0]         sq_root;
    logic signed [COORD_W-1:0] mop, dop;
    logic signed [SUM_W-1:0]   cv [3];
    logic                      neg1, neg2;

    srpc_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (sq_req),
        .o_done (sq_done),
        .o_root (sq_root)
    );

    always_comb begin
        case (r_midx)
            3'd0:    mop = r_item.b_x;
            3'd1:    mop = r_item.b_y;
            3'd2:    mop = r_item.b_z;
            3'd3:    mop = r_item.c_x;
            3'd4:    mop = r_item.c_y;
            default: mop = r_item.c_z;
        endcase
        case (r_didx)
            2'd0:    dop = r_v[0];
            2'd1:    dop = r_v[1];
            default: dop = r_v[2];
        endcase
    end

    // Corner k: tangent one negated for k = 1, 2; tangent two negated for k = 2, 3.
    assign neg1 = r_k[0] ^ r_k[1];
    assign neg2 = r_k[1];
    always_comb begin
        cv[0] = SUM_W'(r_item.a_x) + (neg1 ? -SUM_W'(r_t[0]) : SUM_W'(r_t[0]))
              + (neg2 ? -SUM_W'(r_t[3]) : SUM_W'(r_t[3]));
        cv[1] = SUM_W'(r_item.a_y) + (neg1 ? -SUM_W'(r_t[1]) : SUM_W'(r_t[1]))
              + (neg2 ? -SUM_W'(r_t[4]) : SUM_W'(r_t[4]));
        cv[2] = SUM_W'(r_item.a_z) + (neg1 ? -SUM_W'(r_t[2]) : SUM_W'(r_t[2]))
              + (neg2 ? -SUM_W'(r_t[5]) : SUM_W'(r_t[5]));
    end

    assign sum = r_acc + SQ_W'(unsigned'(r_prod));

    always_comb begin
        o_out      = '0;
        o_out_push = 1'b0;
        case (r_state)
            S_EMIT_T1: begin
                o_out.kind  = KIND_TAN1;
                o_out.vec_x = sat_c(SUM_W'(r_t[0]));
                o_out.vec_y = sat_c(SUM_W'(r_t[1]));
                o_out.vec_z = sat_c(SUM_W'(r_t[2]));
                o_out_push  = !i_out_full;
            end
            S_EMIT_T2: begin
                o_out.kind  = KIND_TAN2;
                o_out.vec_x = sat_c(SUM_W'(r_t[3]));
                o_out.vec_y = sat_c(SUM_W'(r_t[4]));
                o_out.vec_z = sat_c(SUM_W'(r_t[5]));
                o_out_push  = !i_out_full;
            end
            S_EMIT_C: begin
                o_out.kind         = KIND_CORNER;
                o_out.corner_index = r_k;
                o_out.vec_x        = r_v[0];
                o_out.vec_y        = r_v[1];
                o_out.vec_z        = r_v[2];
                o_out.last_result  = (r_k == 2'd3) && !r_item.last_item;
                o_out_push         = !i_out_full;
            end
            S_EMIT_R: begin
                o_out.kind        = KIND_RADIUS;
                o_out.radius      = (COORD_W + 1)'(sq_root);
                o_out.generation  = r_deck + GEN_W'(1);
                o_out.last_result = 1'b1;
                o_out_push        = !i_out_full;
            end
            default: ;
        endcase
    end

    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_max   <= '0;
            r_deck  <= '0;
            sq_req  <= '0;
        end else begin
            sq_req.start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_item <= i_q_item;
                        if (!i_q_item.cmd) begin
                            r_v[0]  <= i_q_item.a_x;
                            r_v[1]  <= i_q_item.a_y;
                            r_v[2]  <= i_q_item.a_z;
                            r_phase <= P_WIRE_A;
                            r_didx  <= '0;
                            r_acc   <= '0;
                            r_state <= S_DIST;
                        end else begin
                            sq_req.start  <= 1'b1;
                            sq_req.rad    <= {i_q_item.area, FRAC_BITS'(0),
                                              (SQ_W - COORD_W - FRAC_BITS)'(0)};
                            sq_req.iters  <= ITER_W'(AREA_ITER);
                            r_sqrt_radius <= 1'b0;
                            r_state       <= S_SQRT;
                        end
                    end
                end
                S_SQRT: begin
                    if (sq_done) begin
                        if (r_sqrt_radius) begin
                            r_state <= S_EMIT_R;
                        end else begin
                            r_s     <= sq_root[S_W:1];
                            r_midx  <= '0;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    // issue one product a cycle, round the previous one
                    if (r_midx < 3'd6) begin
                        r_mprod <= $signed({1'b0, r_s}) * mop;
                    end
                    if (r_midx != 3'd0) begin
                        r_t[r_midx - 3'd1] <= round_t(r_mprod);
                    end
                    r_midx <= r_midx + 3'd1;
                    if (r_midx == 3'd6) r_state <= S_EMIT_T1;
                end
                S_EMIT_T1: if (!i_out_full) r_state <= S_EMIT_T2;
                S_EMIT_T2: begin
                    if (!i_out_full) begin
                        r_k     <= '0;
                        r_state <= S_CORNER;
                    end
                end
                S_CORNER: begin
                    r_v[0]  <= sat_c(cv[0]);
                    r_v[1]  <= sat_c(cv[1]);
                    r_v[2]  <= sat_c(cv[2]);
                    r_phase <= P_CORNER;
                    r_didx  <= '0;
                    r_acc   <= '0;
                    r_state <= S_DIST;
                end
                S_DIST: begin
                    if (r_didx != 2'd3) begin
                        r_prod <= dop * dop;
                    end
                    if (r_didx != 2'd0) begin
                        r_acc <= sum;
                    end
                    r_didx <= r_didx + 2'd1;
                    if (r_didx == 2'd3) begin
                        if (sum > r_max) r_max <= sum;
                        case (r_phase)
                            P_WIRE_A: begin
                                r_v[0]  <= r_item.b_x;
                                r_v[1]  <= r_item.b_y;
                                r_v[2]  <= r_item.b_z;
                                r_phase <= P_WIRE_B;
                                r_acc   <= '0;
                            end
                            P_CORNER: r_state <= S_EMIT_C;
                            default: begin
                                if (r_item.last_item) begin
                                    sq_req.start  <= 1'b1;
                                    sq_req.rad    <= (sum > r_max) ? sum : r_max;
                                    sq_req.iters  <= ITER_W'(ROOT_W);
                                    r_sqrt_radius <= 1'b1;
                                    r_state       <= S_SQRT;
                                end else begin
                                    r_state <= S_IDLE;
                                end
                            end
                        endcase
                    end
                end
                S_EMIT_C: begin
                    if (!i_out_full) begin
                        r_k <= r_k + 2'd1;
                        if (r_k != 2'd3) begin
                            r_state <= S_CORNER;
                        end else if (r_item.last_item) begin
                            sq_req.start  <= 1'b1;
                            sq_req.rad    <= r_max;
                            sq_req.iters  <= ITER_W'(ROOT_W);
                            r_sqrt_radius <= 1'b1;
                            r_state       <= S_SQRT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_EMIT_R: begin
                    if (!i_out_full) begin
                        r_deck  <= r_deck + GEN_W'(1);
                        r_max   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/srpc_outq.sv]
// Four-entry result queue between the sequencer and the result port.
// Depends on srpc_pkg.
module srpc_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  srpc_pkg::t_result i_res,
    output logic              empty,
    input  logic              pop,
    output srpc_pkg::t_result o_result
);
    import srpc_pkg::*;

    t_result    r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       wr, rd;

    assign o_full   = (r_cnt == 3'd4);
    assign empty    = (r_cnt == 3'd0);
    assign o_result = r_mem[r_rp];
    assign wr       = i_push && !o_full;
    assign rd       = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_res;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 2'd1;
            if (rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(wr) - 3'(rd);
        end
    end
endmodule

[rtl/scene_radius_and_patch_corners.sv]
// Top level of the scene radius and patch corner block.
// Depends on srpc_pkg, srpc_front, srpc_back, srpc_outq.
//
// Items enter through a two-entry queue and are worked one at a time by a sequencer with an
// 18x24 scaling multiplier, a 24x24 squarer and a one-bit-per-cycle square root unit; results
// leave through a four-entry queue. A wire measures the squared distance of both end points.
// A patch takes the request, runs the 18-step square root, the scaling multiplies, 2 tangent
// emits and 4 corners. A last item adds the 25-step radius root and the radius emit. Result
// emits stall only while the result queue is full.
module scene_radius_and_patch_corners (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  srpc_pkg::t_item   i_item,
    output logic              empty,
    input  logic              pop,
    output srpc_pkg::t_result o_result
);
    import srpc_pkg::*;

    logic    q_empty, q_pop, out_full, out_push;
    t_item   q_item;
    t_result out_res;

    srpc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_item(i_item),
        .o_q_empty(q_empty), .i_q_pop(q_pop), .o_q_item(q_item)
    );

    srpc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_empty(q_empty), .o_q_pop(q_pop),
        .i_q_item(q_item), .i_out_full(out_full), .o_out_push(out_push), .o_out(out_res)
    );

    srpc_outq u_outq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(out_push), .o_full(out_full),
        .i_res(out_res), .empty(empty), .pop(pop), .o_result(o_result)
    );
endmodule

[rtl/srpc_checker.sv]
// Port-level checks for the scene radius and patch corner block, bound to the top level.
// Depends on srpc_pkg.
module srpc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              empty,
    input logic              pop,
    input srpc_pkg::t_result o_result
);
    import srpc_pkg::*;

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> empty) else $error("result queue not empty after reset");

    a_radius_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.kind == KIND_RADIUS) |-> o_result.last_result)
        else $error("radius result not marked last");

    a_radius_no_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.kind == KIND_RADIUS) |->
        (o_result.vec_x == '0 && o_result.vec_y == '0 && o_result.vec_z == '0))
        else $error("radius result carries a vector");

    a_index_corner_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.kind != KIND_CORNER) |->
        (o_result.corner_index == 2'd0 && (o_result.kind == KIND_RADIUS ||
         (o_result.radius == '0 && o_result.generation == '0))))
        else $error("stray corner index or radius fields");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed");
endmodule

bind scene_radius_and_patch_corners srpc_checker u_srpc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .empty(empty), .pop(pop), .o_result(o_result)
);
